@@ hw/rtl/cpn_pkg.sv @@
// ----------------------------------------------------------------------------
// cpn_pkg
// Shared types, widths and codes of the contour point normal block.
// ----------------------------------------------------------------------------
package cpn_pkg;

    localparam int COORD_BITS       = 32;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_BITS      = 16;
    localparam int PLANE_BITS       = 16;
    localparam int CFG_DATA_BITS    = 16;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int COUNT_BITS       = 16;

    // difference needs COORD_BITS+1 bits, below the 40 bit limit: no prescale
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = DIFF_W + PLANE_BITS;
    localparam int CROSS_W = PROD_W + 1;
    localparam int NORM_W  = 31;
    localparam int SQ_W    = 2 * NORM_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int NUM_W   = NORM_W + NORMAL_FRAC_BITS + 1;
    localparam int QUOT_W  = NORMAL_FRAC_BITS + 2;
    localparam int STEP_W  = 6;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_NORMALS_EN = 3'd0,
        CFG_IN_PLANE   = 3'd1,
        CFG_CLOSED     = 3'd2,
        CFG_DEDUP      = 3'd3,
        CFG_PLANE_NX   = 3'd4,
        CFG_PLANE_NY   = 3'd5,
        CFG_PLANE_NZ   = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        EM_OPEN_FIRST = 3'd0,
        EM_MID        = 3'd1,
        EM_SINGLE     = 3'd2,
        EM_END        = 3'd3,
        EM_WRAP       = 3'd4
    } emit_kind_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [15:0]                  contour_id;
        logic                         last_point;
    } in_item_t;

    typedef struct packed {
        logic [15:0]                   point_index;
        logic [15:0]                   marker_type;
        logic signed [COORD_BITS-1:0]  out_x;
        logic signed [COORD_BITS-1:0]  out_y;
        logic signed [COORD_BITS-1:0]  out_z;
        logic signed [NORMAL_BITS-1:0] normal_x;
        logic signed [NORMAL_BITS-1:0] normal_y;
        logic signed [NORMAL_BITS-1:0] normal_z;
        logic                          last_result;
    } out_item_t;

    typedef struct packed {
        logic              in_load;
        logic              load;
        emit_kind_t        kind;
        logic              mul_en;
        logic              mag;
        logic              norm_shift;
        logic              sq_en;
        logic              sqrt_init;
        logic              sqrt_en;
        logic              div_init;
        logic              div_en;
        logic              div_store;
        logic [1:0]        comp;
        logic [STEP_W-1:0] step;
        logic              out_load;
        logic              upd;
        logic              clr;
    } dp_cmd_t;

    typedef struct packed {
        logic dup;
        logic cnt_zero;
        logic cnt_one;
        logic last;
        logic closed;
        logic nrm_en;
        logic c_zero;
        logic norm_done;
    } dp_status_t;

endpackage

@@ hw/rtl/contour_point_normals.sv @@
// ----------------------------------------------------------------------------
// contour_point_normals
// Per-point markers with unit normals for planar contours.
// ----------------------------------------------------------------------------
// One item is handled at a time: accept, decide and history update, plus the
// markers the item makes. A marker without a normal goes from load straight
// to the output load; with normals on, a marker runs the cross product (six
// products on one shared multiplier), a one-bit-per-cycle normalize shifter,
// three squares, a 32-step square root and a 16-step divide for each of the
// three components before the output load.
// An item makes zero to three markers; each waits in the output register
// until taken, and no new item is taken while one is in progress.
module contour_point_normals (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cpn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [cpn_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cpn_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cpn_pkg::out_item_t                  out_item
);
    import cpn_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    cpn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cpn_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a marker is pending");

endmodule

@@ hw/rtl/cpn_datapath.sv @@
// ----------------------------------------------------------------------------
// cpn_datapath
// Point history, configuration, cross product, normalize, square root and
// divide units, and the output register.
// ----------------------------------------------------------------------------
module cpn_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cpn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [cpn_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  cpn_pkg::in_item_t                   in_item,
    input  cpn_pkg::dp_cmd_t                    cmd,
    output cpn_pkg::dp_status_t                 status,
    output cpn_pkg::out_item_t                  out_item
);
    import cpn_pkg::*;

    localparam int QX_W = (QUOT_W > 17) ? QUOT_W : 17;

    logic                         nen_reg, inpl_reg, closed_reg, dedup_reg;
    logic signed [PLANE_BITS-1:0] pn_reg [3];

    in_item_t                     in_reg;
    logic signed [COORD_BITS-1:0] first_reg  [3];
    logic signed [COORD_BITS-1:0] second_reg [3];
    logic signed [COORD_BITS-1:0] prev_reg   [3];
    logic signed [COORD_BITS-1:0] cur_reg    [3];
    logic signed [COORD_BITS-1:0] inpos      [3];
    logic [COUNT_BITS-1:0]        cnt_reg;

    logic signed [COORD_BITS-1:0] sel_pt  [3];
    logic signed [COORD_BITS-1:0] sel_prv [3];
    logic signed [COORD_BITS-1:0] sel_nxt [3];
    logic signed [COORD_BITS-1:0] e_pt_reg [3];
    logic [15:0]                  e_idx_reg;
    logic [15:0]                  e_idx_next;
    logic                         e_last_reg;
    logic                         e_last_next;

    logic signed [DIFF_W-1:0]     d_reg [3];
    logic signed [DIFF_W-1:0]     mul_a;
    logic signed [PLANE_BITS-1:0] mul_b;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [PROD_W-1:0]     prod_reg;
    logic [2:0]                   acc_sel_reg;
    logic                         acc_vld_reg;
    logic signed [CROSS_W-1:0]    c_reg [3];

    logic [CROSS_W-1:0]           mag_reg [3];
    logic                         neg_reg [3];
    logic [CROSS_W-1:0]           mor;

    logic [NORM_W-1:0]            sq_op;
    logic [SQ_W-1:0]              sq_next;
    logic [SQ_W-1:0]              sq_reg;
    logic [1:0]                   sq_sel_reg;
    logic                         sq_vld_reg;
    logic [SUM_W-1:0]             sum_reg;

    logic [SUM_W-1:0]             sqs_reg;
    logic [ROOT_W+2:0]            srem_reg;
    logic [ROOT_W-1:0]            root_reg;
    logic [ROOT_W+2:0]            srem2;
    logic [ROOT_W+2:0]            strial;

    logic [NUM_W-1:0]             num;
    logic [ROOT_W:0]              drem_reg;
    logic [QUOT_W-1:0]            nlo_reg;
    logic [QUOT_W-1:0]            q_reg;
    logic [ROOT_W:0]              drem2;
    logic                         dge;
    logic [QX_W-1:0]              qx;
    logic [QX_W-1:0]              qneg;
    logic [NORMAL_BITS-1:0]       nval;
    logic signed [NORMAL_BITS-1:0] nrm_reg [3];

    out_item_t                    out_reg;

    assign inpos[0] = in_reg.pos_x;
    assign inpos[1] = in_reg.pos_y;
    assign inpos[2] = in_reg.pos_z;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nen_reg    <= 1'b0;
            inpl_reg   <= 1'b0;
            closed_reg <= 1'b0;
            dedup_reg  <= 1'b0;
            pn_reg[0]  <= '0;
            pn_reg[1]  <= '0;
            pn_reg[2]  <= PLANE_BITS'(1 << NORMAL_FRAC_BITS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NORMALS_EN: nen_reg    <= cfg_data[0];
                CFG_IN_PLANE:   inpl_reg   <= cfg_data[0];
                CFG_CLOSED:     closed_reg <= cfg_data[0];
                CFG_DEDUP:      dedup_reg  <= cfg_data[0];
                CFG_PLANE_NX:   pn_reg[0]  <= cfg_data[PLANE_BITS-1:0];
                CFG_PLANE_NY:   pn_reg[1]  <= cfg_data[PLANE_BITS-1:0];
                CFG_PLANE_NZ:   pn_reg[2]  <= cfg_data[PLANE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // point history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.upd && cnt_reg != COUNT_MAX)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            in_reg <= in_item;
        end
        if (cmd.upd)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cnt_reg == '0)
                begin
                    first_reg[i] <= inpos[i];
                    prev_reg[i]  <= inpos[i];
                end
                else
                begin
                    prev_reg[i] <= cur_reg[i];
                end
                if (cnt_reg == COUNT_BITS'(1))
                begin
                    second_reg[i] <= inpos[i];
                end
                cur_reg[i] <= inpos[i];
            end
        end
    end

    assign status.dup      = dedup_reg && (cnt_reg != '0) && (inpos[0] == cur_reg[0])
                             && (inpos[1] == cur_reg[1]) && (inpos[2] == cur_reg[2]);
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.cnt_one  = (cnt_reg == COUNT_BITS'(1));
    assign status.last     = in_reg.last_point;
    assign status.closed   = closed_reg;
    assign status.nrm_en   = nen_reg && inpl_reg;

    // marker operands
    always_comb
    begin
        e_idx_next  = '0;
        e_last_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sel_pt[i]  = cur_reg[i];
            sel_prv[i] = prev_reg[i];
            sel_nxt[i] = inpos[i];
        end
        case (cmd.kind)
            EM_OPEN_FIRST:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sel_pt[i]  = first_reg[i];
                    sel_prv[i] = first_reg[i];
                end
            end
            EM_MID:
            begin
                e_idx_next = cnt_reg - 1'b1;
            end
            EM_SINGLE:
            begin
                e_last_next = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    sel_prv[i] = cur_reg[i];
                    sel_nxt[i] = cur_reg[i];
                end
            end
            EM_END:
            begin
                e_idx_next  = cnt_reg - 1'b1;
                e_last_next = !closed_reg;
                for (int i = 0; i < 3; i++)
                begin
                    sel_nxt[i] = closed_reg ? first_reg[i] : cur_reg[i];
                end
            end
            EM_WRAP:
            begin
                e_last_next = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    sel_pt[i]  = first_reg[i];
                    sel_prv[i] = cur_reg[i];
                    sel_nxt[i] = second_reg[i];
                end
            end
            default: ;
        endcase
    end

    // cross product: one shared multiplier, six products
    always_comb
    begin
        mul_a = d_reg[1];
        mul_b = pn_reg[2];
        case (cmd.step[2:0])
            3'd0: begin mul_a = d_reg[1]; mul_b = pn_reg[2]; end
            3'd1: begin mul_a = d_reg[2]; mul_b = pn_reg[1]; end
            3'd2: begin mul_a = d_reg[2]; mul_b = pn_reg[0]; end
            3'd3: begin mul_a = d_reg[0]; mul_b = pn_reg[2]; end
            3'd4: begin mul_a = d_reg[0]; mul_b = pn_reg[1]; end
            3'd5: begin mul_a = d_reg[1]; mul_b = pn_reg[0]; end
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign mor = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign status.c_zero    = (mor == '0);
    assign status.norm_done = !(|mor[CROSS_W-1:NORM_W]) && mor[NORM_W-1];

    assign sq_op   = mag_reg[cmd.step[1:0]][NORM_W-1:0];
    assign sq_next = sq_op * sq_op;

    assign srem2  = {srem_reg[ROOT_W:0], sqs_reg[SUM_W-1 -: 2]};
    assign strial = {1'b0, root_reg, 2'b01};

    assign num   = NUM_W'({mag_reg[cmd.comp][NORM_W-1:0], {NORMAL_FRAC_BITS{1'b0}}})
                   + NUM_W'(root_reg >> 1);
    assign drem2 = {drem_reg[ROOT_W-1:0], nlo_reg[QUOT_W-1]};
    assign dge   = (drem2 >= {1'b0, root_reg});

    always_comb
    begin
        qx = QX_W'(q_reg);
        if (qx > QX_W'(32768))
        begin
            qx = QX_W'(32768);
        end
        qneg = ~qx + 1'b1;
        if (neg_reg[cmd.comp])
        begin
            nval = qneg[NORMAL_BITS-1:0];
        end
        else if (qx > QX_W'(32767))
        begin
            nval = NORMAL_BITS'(32767);
        end
        else
        begin
            nval = qx[NORMAL_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= 1'b0;
            sq_vld_reg  <= 1'b0;
        end
        else
        begin
            acc_vld_reg <= cmd.mul_en;
            sq_vld_reg  <= cmd.sq_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_idx_reg  <= e_idx_next;
            e_last_reg <= e_last_next;
            for (int i = 0; i < 3; i++)
            begin
                e_pt_reg[i] <= sel_pt[i];
                d_reg[i]    <= {sel_nxt[i][COORD_BITS-1], sel_nxt[i]}
                               - {sel_prv[i][COORD_BITS-1], sel_prv[i]};
                nrm_reg[i]  <= '0;
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg    <= prod_next;
            acc_sel_reg <= cmd.step[2:0];
        end
        if (acc_vld_reg)
        begin
            if (!acc_sel_reg[0])
            begin
                c_reg[acc_sel_reg[2:1]] <= {prod_reg[PROD_W-1], prod_reg};
            end
            else
            begin
                c_reg[acc_sel_reg[2:1]] <= c_reg[acc_sel_reg[2:1]]
                                           - {prod_reg[PROD_W-1], prod_reg};
            end
        end
        if (cmd.mag)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= c_reg[i][CROSS_W-1];
                mag_reg[i] <= c_reg[i][CROSS_W-1] ? CROSS_W'(-c_reg[i]) : CROSS_W'(c_reg[i]);
            end
        end
        if (cmd.norm_shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (|mor[CROSS_W-1:NORM_W])
                begin
                    mag_reg[i] <= mag_reg[i] >> 1;
                end
                else
                begin
                    mag_reg[i] <= mag_reg[i] << 1;
                end
            end
        end
        if (cmd.sq_en)
        begin
            sq_reg     <= sq_next;
            sq_sel_reg <= cmd.step[1:0];
        end
        if (sq_vld_reg)
        begin
            sum_reg <= (sq_sel_reg == 2'd0) ? SUM_W'(sq_reg) : sum_reg + SUM_W'(sq_reg);
        end
        if (cmd.sqrt_init)
        begin
            sqs_reg  <= sum_reg;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_en)
        begin
            sqs_reg <= sqs_reg << 2;
            if (srem2 >= strial)
            begin
                srem_reg <= srem2 - strial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem2;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            drem_reg <= (ROOT_W+1)'(num[NUM_W-1:QUOT_W]);
            nlo_reg  <= num[QUOT_W-1:0];
            q_reg    <= '0;
        end
        else if (cmd.div_en)
        begin
            drem_reg <= dge ? drem2 - {1'b0, root_reg} : drem2;
            nlo_reg  <= nlo_reg << 1;
            q_reg    <= {q_reg[QUOT_W-2:0], dge};
        end
        if (cmd.div_store)
        begin
            nrm_reg[cmd.comp] <= nval;
        end
        if (cmd.out_load)
        begin
            out_reg.point_index <= e_idx_reg;
            out_reg.marker_type <= in_reg.contour_id;
            out_reg.out_x       <= e_pt_reg[0];
            out_reg.out_y       <= e_pt_reg[1];
            out_reg.out_z       <= e_pt_reg[2];
            out_reg.normal_x    <= nrm_reg[0];
            out_reg.normal_y    <= nrm_reg[1];
            out_reg.normal_z    <= nrm_reg[2];
            out_reg.last_result <= e_last_reg;
        end
    end

    assign out_item = out_reg;

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> root_reg[ROOT_W-1:ROOT_W-2] != 2'b00)
        else $error("square root below normalized range");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_store |-> q_reg <= QUOT_W'(1 << NORMAL_FRAC_BITS))
        else $error("normal component above unit length");

endmodule

@@ hw/rtl/cpn_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpn_ctrl
// Sequencer: per-item decisions, marker order and normal computation steps.
// ----------------------------------------------------------------------------
module cpn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  cpn_pkg::dp_status_t status,
    output cpn_pkg::dp_cmd_t    cmd
);
    import cpn_pkg::*;

    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(5);
    localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(2);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUOT_W - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_ACHK, S_LOAD, S_MUL, S_MACC, S_MAG, S_NORM, S_SQ, S_SACC,
        S_SQI, S_SQRT, S_DINIT, S_DIV, S_DSTORE, S_FIN, S_OUT, S_UPD, S_BCHK, S_CLR
    } state_t;

    state_t            state_reg, state_next;
    emit_kind_t        kind_reg, kind_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        comp_reg, comp_next;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        step_next  = step_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        cmd.step   = step_reg;
        cmd.comp   = comp_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.in_load = in_valid;
                if (in_valid)
                begin
                    state_next = S_ACHK;
                end
            end
            S_ACHK:
            begin
                if (status.dup)
                begin
                    state_next = S_BCHK;
                end
                else if (status.cnt_zero || (status.cnt_one && status.closed))
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    kind_next  = status.cnt_one ? EM_OPEN_FIRST : EM_MID;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                comp_next  = '0;
                state_next = status.nrm_en ? S_MUL : S_FIN;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                step_next  = step_reg + 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    state_next = S_MACC;
                end
            end
            S_MACC:
            begin
                state_next = S_MAG;
            end
            S_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                step_next = '0;
                if (status.c_zero)
                begin
                    state_next = S_FIN;
                end
                else if (status.norm_done)
                begin
                    state_next = S_SQ;
                end
                else
                begin
                    cmd.norm_shift = 1'b1;
                end
            end
            S_SQ:
            begin
                cmd.sq_en = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == SQ_LAST)
                begin
                    state_next = S_SACC;
                end
            end
            S_SACC:
            begin
                state_next = S_SQI;
            end
            S_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_en = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == SQRT_LAST)
                begin
                    state_next = S_DINIT;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_en = 1'b1;
                step_next  = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = S_DSTORE;
                end
            end
            S_DSTORE:
            begin
                cmd.div_store = 1'b1;
                if (comp_reg == 2'd2)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = S_DINIT;
                end
            end
            S_FIN:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    case (kind_reg) inside
                        EM_OPEN_FIRST, EM_MID: state_next = S_UPD;
                        EM_END:
                        begin
                            if (status.closed)
                            begin
                                kind_next  = EM_WRAP;
                                state_next = S_LOAD;
                            end
                            else
                            begin
                                state_next = S_CLR;
                            end
                        end
                        default: state_next = S_CLR;
                    endcase
                end
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (status.last && !status.cnt_zero)
                begin
                    kind_next  = status.cnt_one ? EM_SINGLE : EM_END;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                cmd.clr    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= EM_MID;
            step_reg  <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            step_reg  <= step_next;
            comp_reg  <= comp_next;
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken before the first was handled");

    a_wrap_closed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && kind_reg == EM_WRAP |-> status.closed)
        else $error("wrap marker on an open contour");

endmodule
